// ===== hdl/vac_pkg.sv =====
// ----------------------------------------------------------------------------
// vac_pkg
// Shared widths, latencies and sideband type of the vector angle pipeline.
// ----------------------------------------------------------------------------
package vac_pkg;

	localparam int COMP_W   = 16;
	localparam int FRAC_W   = 15;
	localparam int COS_W    = FRAC_W + 1;
	localparam int LEN_W    = 2 * COMP_W;
	localparam int DOT_W    = 2 * COMP_W + 2;
	localparam int SQ_IN_W  = 2 * LEN_W;
	localparam int SQ_OUT_W = SQ_IN_W / 2;
	localparam int SQ_REM_W = SQ_OUT_W + 3;
	localparam int FRONT_LAT = 3;
	localparam int SQ_LAT    = SQ_OUT_W;
	localparam int DIV_LAT   = FRAC_W + 4;
	localparam int TOTAL_LAT = FRONT_LAT + SQ_LAT + DIV_LAT + SQ_LAT + 1;

	localparam logic [SQ_OUT_W-1:0] SIN_MAX = SQ_OUT_W'((1 << FRAC_W) - 1);
	localparam logic [2*COS_W-1:0]  FULL_SQ = (2*COS_W)'(1) << (2 * FRAC_W);

	typedef struct packed {
		logic                    zero;
		logic                    neg;
		logic [LEN_W-1:0]        mag;
		logic signed [COS_W-1:0] cosv;
	} side_t;

endpackage

// ===== hdl/vector_angle_cos_sin.sv =====
// ----------------------------------------------------------------------------
// vector_angle_cos_sin
// Cosine and sine of the angle between two signed 3-component vectors.
// ----------------------------------------------------------------------------
// Channel   Signals                          Transaction
// input     start, busy, a_*, b_*            start high while busy is low
// result    done, cos_angle, sin_angle,      done high for one cycle
//           zero_length
//
// One transaction can enter every cycle; busy is always low.
// Each result follows its input through the front end, the two 32-stage square
// root pipelines, the divide with its 15 quotient steps and the output register.
// Reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never stops.
// ----------------------------------------------------------------------------
module vector_angle_cos_sin (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [vac_pkg::COMP_W-1:0]   a_x,
	input  logic signed [vac_pkg::COMP_W-1:0]   a_y,
	input  logic signed [vac_pkg::COMP_W-1:0]   a_z,
	input  logic signed [vac_pkg::COMP_W-1:0]   b_x,
	input  logic signed [vac_pkg::COMP_W-1:0]   b_y,
	input  logic signed [vac_pkg::COMP_W-1:0]   b_z,
	output logic                                done,
	output logic signed [vac_pkg::COS_W-1:0]    cos_angle,
	output logic [vac_pkg::FRAC_W-1:0]          sin_angle,
	output logic                                zero_length
);
	import vac_pkg::*;

	logic                f_valid, q1_valid, d_valid, q2_valid;
	logic [SQ_IN_W-1:0]  f_prod, d_rad;
	logic [SQ_OUT_W-1:0] q1_root, q2_root;
	side_t               f_side, q1_side, d_side, q2_side;
	logic                done_q, zero_q;
	logic signed [COS_W-1:0] cos_q;
	logic [FRAC_W-1:0]   sin_q;

	vac_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.out_valid(f_valid), .out_prod(f_prod), .out_side(f_side)
	);

	vac_isqrt u_len_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_rad(f_prod),
		.in_side(f_side), .out_valid(q1_valid), .out_root(q1_root), .out_side(q1_side)
	);

	vac_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(q1_valid), .in_root(q1_root),
		.in_side(q1_side), .out_valid(d_valid), .out_rad(d_rad), .out_side(d_side)
	);

	vac_isqrt u_sin_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(d_valid), .in_rad(d_rad),
		.in_side(d_side), .out_valid(q2_valid), .out_root(q2_root), .out_side(q2_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= q2_valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_q <= q2_side.zero;
		if (q2_side.zero) begin
			cos_q <= '0;
			sin_q <= '0;
		end else begin
			cos_q <= q2_side.cosv;
			sin_q <= (q2_root > SIN_MAX) ? FRAC_W'(SIN_MAX) : q2_root[FRAC_W-1:0];
		end
	end

	assign busy        = 1'b0;
	assign done        = done_q;
	assign cos_angle   = cos_q;
	assign sin_angle   = sin_q;
	assign zero_length = zero_q;

endmodule

// ===== hdl/vac_front.sv =====
// ----------------------------------------------------------------------------
// vac_front
// Products, dot product and squared lengths, then the product of the squared lengths.
// ----------------------------------------------------------------------------
module vac_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [vac_pkg::COMP_W-1:0]  a_x,
	input  logic signed [vac_pkg::COMP_W-1:0]  a_y,
	input  logic signed [vac_pkg::COMP_W-1:0]  a_z,
	input  logic signed [vac_pkg::COMP_W-1:0]  b_x,
	input  logic signed [vac_pkg::COMP_W-1:0]  b_y,
	input  logic signed [vac_pkg::COMP_W-1:0]  b_z,
	output logic                               out_valid,
	output logic [vac_pkg::SQ_IN_W-1:0]        out_prod,
	output vac_pkg::side_t                     out_side
);
	import vac_pkg::*;

	logic signed [LEN_W-1:0] p_s1 [0:8];
	logic                    vld_s1, vld_s2, vld_s3;
	logic [LEN_W-1:0]        la_s2, lb_s2;
	logic signed [DOT_W-1:0] d_s2;
	logic [SQ_IN_W-1:0]      prod_s3;
	side_t                   side_s3;
	logic [LEN_W-1:0]        la_c, lb_c;
	logic signed [DOT_W-1:0] d_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1[0] <= a_x * a_x;
		p_s1[1] <= a_y * a_y;
		p_s1[2] <= a_z * a_z;
		p_s1[3] <= b_x * b_x;
		p_s1[4] <= b_y * b_y;
		p_s1[5] <= b_z * b_z;
		p_s1[6] <= a_x * b_x;
		p_s1[7] <= a_y * b_y;
		p_s1[8] <= a_z * b_z;
	end

	always_comb begin
		la_c = LEN_W'(unsigned'(p_s1[0])) + LEN_W'(unsigned'(p_s1[1]))
			+ LEN_W'(unsigned'(p_s1[2]));
		lb_c = LEN_W'(unsigned'(p_s1[3])) + LEN_W'(unsigned'(p_s1[4]))
			+ LEN_W'(unsigned'(p_s1[5]));
		d_c = DOT_W'(p_s1[6]) + DOT_W'(p_s1[7]) + DOT_W'(p_s1[8]);
	end

	always_ff @(posedge clk) begin
		la_s2 <= la_c;
		lb_s2 <= lb_c;
		d_s2  <= d_c;
	end

	always_ff @(posedge clk) begin
		prod_s3       <= SQ_IN_W'(la_s2) * SQ_IN_W'(lb_s2);
		side_s3.zero  <= (la_s2 == '0) || (lb_s2 == '0);
		side_s3.neg   <= d_s2[DOT_W-1];
		side_s3.mag   <= d_s2[DOT_W-1] ? LEN_W'(-d_s2) : LEN_W'(d_s2);
		side_s3.cosv  <= '0;
	end

	assign out_valid = vld_s3;
	assign out_prod  = prod_s3;
	assign out_side  = side_s3;

endmodule

// ===== hdl/vac_isqrt.sv =====
// ----------------------------------------------------------------------------
// vac_isqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vac_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [vac_pkg::SQ_IN_W-1:0]  in_rad,
	input  vac_pkg::side_t               in_side,
	output logic                         out_valid,
	output logic [vac_pkg::SQ_OUT_W-1:0] out_root,
	output vac_pkg::side_t               out_side
);
	import vac_pkg::*;

	logic                  vld_s  [0:SQ_OUT_W];
	logic [SQ_IN_W-1:0]    rad_s  [0:SQ_OUT_W];
	logic [SQ_REM_W-1:0]   rem_s  [0:SQ_OUT_W];
	logic [SQ_OUT_W-1:0]   root_s [0:SQ_OUT_W];
	side_t                 side_s [0:SQ_OUT_W];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = in_rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_step
		logic [SQ_REM_W-1:0] cur;
		logic [SQ_REM_W-1:0] trial;
		logic                take;

		always_comb begin
			cur   = {rem_s[k][SQ_REM_W-3:0], rad_s[k][SQ_IN_W-1 -: 2]};
			trial = {1'b0, root_s[k], 2'b01};
			take  = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= rad_s[k] << 2;
			rem_s[k+1]  <= take ? cur - trial : cur;
			root_s[k+1] <= {root_s[k][SQ_OUT_W-2:0], take};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[SQ_OUT_W];
	assign out_root  = root_s[SQ_OUT_W];
	assign out_side  = side_s[SQ_OUT_W];

endmodule

// ===== hdl/vac_div.sv =====
// ----------------------------------------------------------------------------
// vac_div
// Pipelined fraction divide for the cosine, then the sine radicand.
// ----------------------------------------------------------------------------
module vac_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [vac_pkg::SQ_OUT_W-1:0] in_root,
	input  vac_pkg::side_t               in_side,
	output logic                         out_valid,
	output logic [vac_pkg::SQ_IN_W-1:0]  out_rad,
	output vac_pkg::side_t               out_side
);
	import vac_pkg::*;

	logic                  vld_s  [0:FRAC_W];
	logic [LEN_W:0]        r_s    [0:FRAC_W];
	logic [FRAC_W-1:0]     q_s    [0:FRAC_W];
	logic [SQ_OUT_W-1:0]   s_s    [0:FRAC_W];
	logic                  sat_s  [0:FRAC_W];
	side_t                 side_s [0:FRAC_W];

	logic                  vld_c_s, vld_m_s, vld_r_s;
	side_t                 side_c_s, side_m_s, side_r_s;
	logic [2*COS_W-1:0]    csq_m_s;
	logic [SQ_IN_W-1:0]    rad_r_s;
	logic signed [COS_W-1:0] cos_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		r_s[0]    <= {1'b0, in_side.mag};
		q_s[0]    <= '0;
		s_s[0]    <= in_root;
		sat_s[0]  <= in_side.mag >= in_root;
		side_s[0] <= in_side;
	end

	for (genvar k = 0; k < FRAC_W; k++) begin : g_step
		logic [LEN_W:0] sh;
		logic           take;

		always_comb begin
			sh   = {r_s[k][LEN_W-1:0], 1'b0};
			take = sh >= {1'b0, s_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			r_s[k+1]    <= take ? sh - {1'b0, s_s[k]} : sh;
			q_s[k+1]    <= {q_s[k][FRAC_W-2:0], take};
			s_s[k+1]    <= s_s[k];
			sat_s[k+1]  <= sat_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	always_comb begin
		if (sat_s[FRAC_W]) begin
			cos_c = side_s[FRAC_W].neg ? {1'b1, {FRAC_W{1'b0}}} : {1'b0, {FRAC_W{1'b1}}};
		end else begin
			cos_c = side_s[FRAC_W].neg ? -signed'({1'b0, q_s[FRAC_W]})
				: signed'({1'b0, q_s[FRAC_W]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c_s <= 1'b0;
			vld_m_s <= 1'b0;
			vld_r_s <= 1'b0;
		end else begin
			vld_c_s <= vld_s[FRAC_W];
			vld_m_s <= vld_c_s;
			vld_r_s <= vld_m_s;
		end
	end

	always_ff @(posedge clk) begin
		side_c_s      <= '{zero: side_s[FRAC_W].zero, neg: side_s[FRAC_W].neg,
			mag: side_s[FRAC_W].mag, cosv: cos_c};
		csq_m_s       <= unsigned'((2*COS_W)'(side_c_s.cosv) * (2*COS_W)'(side_c_s.cosv));
		side_m_s      <= side_c_s;
		rad_r_s       <= (csq_m_s >= FULL_SQ) ? '0 : SQ_IN_W'(FULL_SQ - csq_m_s);
		side_r_s      <= side_m_s;
	end

	assign out_valid = vld_r_s;
	assign out_rad   = rad_r_s;
	assign out_side  = side_r_s;

endmodule

// ===== hdl/vac_checker.sv =====
// ----------------------------------------------------------------------------
// vac_checker
// Port-level checks of the vector angle block, bound to the top level.
// ----------------------------------------------------------------------------
module vac_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [vac_pkg::COS_W-1:0]  cos_angle,
	input logic [vac_pkg::FRAC_W-1:0]        sin_angle,
	input logic                              zero_length
);
	import vac_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, TOTAL_LAT))
		else $error("result without matching transaction");

	a_zero_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_length |-> cos_angle == '0 && sin_angle == '0)
		else $error("zero length result not cleared");

	a_right_angle: assert property (@(posedge clk) disable iff (!arst_n)
		done && !zero_length && cos_angle == '0 |-> sin_angle == FRAC_W'(SIN_MAX))
		else $error("sine of right angle wrong");

endmodule

bind vector_angle_cos_sin vac_checker u_vac_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.cos_angle(cos_angle), .sin_angle(sin_angle), .zero_length(zero_length)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the vector angle block against an exact integer model of the cosine
// and sine of the angle between two 3-vectors, with directed and random
// vector pairs under varying start gaps.
// ----------------------------------------------------------------------------
module testbench;

	import vac_pkg::*;

	typedef struct {
		logic signed [COMP_W-1:0] ax, ay, az, bx, by, bz;
	} vec_pair_t;

	typedef struct {
		logic signed [COS_W-1:0] cosv;
		logic [FRAC_W-1:0]       sinv;
		logic                    zero;
	} angle_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COMP_W-1:0] a_x = '0, a_y = '0, a_z = '0;
	logic signed [COMP_W-1:0] b_x = '0, b_y = '0, b_z = '0;
	logic done;
	logic signed [COS_W-1:0] cos_angle;
	logic [FRAC_W-1:0] sin_angle;
	logic zero_length;

	vec_pair_t pending_pairs[$];
	angle_t    expected_angles[$];
	int        gap_percent = 0;
	bit        hold_off = 1'b0;
	int        errors = 0;
	int        checked = 0;
	int        zero_seen = 0;

	vector_angle_cos_sin uut (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] root_floor(logic [127:0] v);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] sq;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (64'd1 << i);
			sq = 128'(c) * 128'(c);
			if (sq <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic angle_t angle_of(vec_pair_t p);
		angle_t      res;
		logic [63:0] la, lb, s, mag, q;
		logic signed [63:0] d;
		logic signed [63:0] c;
		logic [63:0] csq, rad, sn;
		la = 64'(p.ax) * p.ax + 64'(p.ay) * p.ay + 64'(p.az) * p.az;
		lb = 64'(p.bx) * p.bx + 64'(p.by) * p.by + 64'(p.bz) * p.bz;
		d = 64'(p.ax) * p.bx + 64'(p.ay) * p.by + 64'(p.az) * p.bz;
		res.cosv = '0;
		res.sinv = '0;
		res.zero = 1'b1;
		if (la == 0 || lb == 0)
			return res;
		s = root_floor(128'(la) * 128'(lb));
		mag = (d < 0) ? -d : d;
		if (mag >= s) begin
			c = (d < 0) ? -(64'sd1 <<< FRAC_W) : (64'sd1 <<< FRAC_W) - 1;
		end else begin
			q = 64'((128'(mag) << FRAC_W) / s);
			c = (d < 0) ? -$signed(q) : $signed(q);
		end
		csq = c * c;
		rad = (csq >= (64'd1 << (2 * FRAC_W))) ? 64'd0 : (64'd1 << (2 * FRAC_W)) - csq;
		sn = root_floor(128'(rad));
		if (sn > (64'd1 << FRAC_W) - 1)
			sn = (64'd1 << FRAC_W) - 1;
		res.cosv = c[COS_W-1:0];
		res.sinv = sn[FRAC_W-1:0];
		res.zero = 1'b0;
		return res;
	endfunction

	function automatic logic signed [COMP_W-1:0] pick_component();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return COMP_W'($signed($urandom_range(0, 8)) - 4);
			3: return 16'sh0000;
			default: return COMP_W'($urandom);
		endcase
	endfunction

	// Driver: a transaction is accepted on the edge where start is high and busy low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!(start && busy)) begin
				if (pending_pairs.size() > 0 && !hold_off &&
						$urandom_range(0, 99) >= gap_percent) begin
					vec_pair_t p;
					p = pending_pairs.pop_front();
					a_x <= p.ax; a_y <= p.ay; a_z <= p.az;
					b_x <= p.bx; b_y <= p.by; b_z <= p.bz;
					expected_angles.insert(expected_angles.size(), angle_of(p));
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && done) begin
			angle_t e;
			if (expected_angles.size() == 0) begin
				$display("%0t: unexpected result cos %0d sin %0d zero %0b", $time,
					cos_angle, sin_angle, zero_length);
				errors++;
			end else begin
				e = expected_angles.pop_front();
				checked++;
				if (e.zero)
					zero_seen++;
				if (cos_angle !== e.cosv) begin
					$display("%0t: cos_angle expected %0d actual %0d", $time, e.cosv, cos_angle);
					errors++;
				end
				if (sin_angle !== e.sinv) begin
					$display("%0t: sin_angle expected %0d actual %0d", $time, e.sinv, sin_angle);
					errors++;
				end
				if (zero_length !== e.zero) begin
					$display("%0t: zero_length expected %0b actual %0b", $time, e.zero,
						zero_length);
					errors++;
				end
			end
		end
	end

	task automatic add_pair(int ax, int ay, int az, int bx, int by, int bz);
		vec_pair_t p;
		p.ax = COMP_W'(ax); p.ay = COMP_W'(ay); p.az = COMP_W'(az);
		p.bx = COMP_W'(bx); p.by = COMP_W'(by); p.bz = COMP_W'(bz);
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	task automatic add_random(int n);
		vec_pair_t p;
		for (int i = 0; i < n; i++) begin
			p.ax = pick_component(); p.ay = pick_component(); p.az = pick_component();
			case ($urandom_range(0, 5))
				0: begin p.bx = p.ax; p.by = p.ay; p.bz = p.az; end
				1: begin p.bx = -p.ax; p.by = -p.ay; p.bz = -p.az; end
				2: begin p.bx = -p.ay; p.by = p.ax; p.bz = '0; end
				default: begin
					p.bx = pick_component(); p.by = pick_component(); p.bz = pick_component();
				end
			endcase
			pending_pairs.insert(pending_pairs.size(), p);
		end
	endtask

	task automatic drain();
		wait (pending_pairs.size() == 0 && !start);
		wait (expected_angles.size() == 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		add_pair(0, 0, 0, 1, 2, 3);
		add_pair(1, 2, 3, 0, 0, 0);
		add_pair(0, 0, 0, 0, 0, 0);
		add_pair(1, 0, 0, 1, 0, 0);
		add_pair(1, 0, 0, -1, 0, 0);
		add_pair(1, 0, 0, 0, 1, 0);
		add_pair(0, 0, 1, 0, 1, 0);
		add_pair(32767, 32767, 32767, 32767, 32767, 32767);
		add_pair(-32768, -32768, -32768, -32768, -32768, -32768);
		add_pair(-32768, -32768, -32768, 32767, 32767, 32767);
		add_pair(-32768, 0, 0, 0, -32768, 0);
		add_pair(3, 4, 0, 4, 3, 0);
		add_pair(1, 1, 1, 1, 1, 0);
		add_pair(32767, -32768, 1, -1, 32767, -32768);
		add_pair(-1, -1, -1, 1, 1, 1);
		add_pair(2, 3, 5, 2, 3, 5);

		gap_percent = 20;
		add_random(580);
		drain();

		hold_off = 1'b1;
		repeat (100) @(posedge clk);
		hold_off = 1'b0;

		gap_percent = 83;
		add_random(580);
		drain();

		gap_percent = 0;
		add_random(580);
		drain();

		repeat (TOTAL_LAT + 20) @(posedge clk);
		$display("Checked %0d results, %0d of them with a zero-length vector.",
			checked, zero_seen);
		$display("Start gaps ran at 20, 83 and 0 percent with one full drain pause.");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/vac_pkg.sv
hdl/vac_front.sv
hdl/vac_isqrt.sv
hdl/vac_div.sv
hdl/vector_angle_cos_sin.sv
hdl/vac_checker.sv
test/testbench.sv
